/* design/menu_key_edge_and_autorepeat_defines.svh */
// Assertion macros for the menu key edge and autorepeat block.
// Used by the top level only; no other dependencies.
`ifndef MENU_KEY_EDGE_AND_AUTOREPEAT_DEFINES_SVH
`define MENU_KEY_EDGE_AND_AUTOREPEAT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every clock edge outside reset.
`define MKAR_ASSERT_IMPL(label, clock, reset_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked at every clock edge outside reset.
`define MKAR_ASSERT_NEXT(label, clock, reset_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MKAR_ASSERT_IMPL(label, clock, reset_n, ante, cons, msg)
`define MKAR_ASSERT_NEXT(label, clock, reset_n, ante, cons, msg)
`endif

`endif

/* design/mkar_pkg.sv */
// Shared types and constants for the menu key edge and autorepeat block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mkar_pkg;

	localparam int unsigned CFG_IDX_BITS  = 2;
	localparam int unsigned CFG_DATA_BITS = 22;
	localparam int unsigned DELAY_BITS    = 22;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] REG_ALT_HOTKEY_EN = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT_DELAY  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT_RATE   = 2'd2;

	localparam logic [DELAY_BITS-1:0] RESET_DELAY_US = 22'd400000;
	localparam logic [DELAY_BITS-1:0] RESET_RATE_US  = 22'd80000;

	// Command codes.
	localparam logic CMD_SNAPSHOT = 1'b0;
	localparam logic CMD_POLL     = 1'b1;

	// Bit positions in the key snapshot.
	localparam int unsigned KB_MENU  = 0;
	localparam int unsigned KB_ALT   = 1;
	localparam int unsigned KB_UP    = 2;
	localparam int unsigned KB_DOWN  = 3;
	localparam int unsigned KB_LEFT  = 4;
	localparam int unsigned KB_RIGHT = 5;
	localparam int unsigned KB_ENTER = 6;
	localparam int unsigned KB_ESC   = 7;

	// Direction lanes.
	localparam int unsigned DIR_UP   = 0;
	localparam int unsigned DIR_DOWN = 1;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  keys;
		logic        menu_open;
		logic        adjusting;
		logic        alt_overlay_keys;
		logic [63:0] now_us;
	} in_item_t;

	typedef struct packed {
		logic        menu_request;
		logic        alt_request;
		logic        alt_overlay_release;
		logic        keyboard_owned;
		logic        back_press;
		logic        select_press;
		logic        up_press;
		logic        down_press;
		logic        up_is_held;
		logic        down_is_held;
		logic [63:0] up_hold_began;
		logic [63:0] down_hold_began;
	} out_item_t;

	typedef struct packed {
		logic                  alt_hotkey_enabled;
		logic [DELAY_BITS-1:0] repeat_delay_us;
		logic [DELAY_BITS-1:0] repeat_rate_us;
	} cfg_t;

endpackage

`default_nettype wire

/* design/mkar_cfg.sv */
// Configuration registers: hotkey enable, repeat delay and repeat rate.
// Depends on mkar_pkg for register indexes and reset values.
`timescale 1ns / 1ps
`default_nettype none

module mkar_cfg import mkar_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [CFG_IDX_BITS-1:0]  index,
	input  logic [CFG_DATA_BITS-1:0] data,
	output cfg_t                     cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alt_hotkey_enabled <= 1'b0;
			cfg_q.repeat_delay_us    <= RESET_DELAY_US;
			cfg_q.repeat_rate_us     <= RESET_RATE_US;
		end else if (we) begin
			unique case (index)
				REG_ALT_HOTKEY_EN: cfg_q.alt_hotkey_enabled <= data[0];
				REG_REPEAT_DELAY:  cfg_q.repeat_delay_us    <= data[DELAY_BITS-1:0];
				REG_REPEAT_RATE:   cfg_q.repeat_rate_us     <= data[DELAY_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* design/mkar_repeat.sv */
// One direction's typematic timer: first press, delayed repeat, then fixed rate.
// Depends on mkar_pkg for the delay field width.
`timescale 1ns / 1ps
`default_nettype none

module mkar_repeat import mkar_pkg::*; #(
	parameter int TIME_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  poll,
	input  logic                  held,
	input  logic [TIME_BITS-1:0]  now,
	input  logic [DELAY_BITS-1:0] delay,
	input  logic [DELAY_BITS-1:0] rate,
	output logic                  press,
	output logic                  seen_nx,
	output logic [TIME_BITS-1:0]  start_nx
);

	logic                 seen_q;
	logic [TIME_BITS-1:0] start_q;
	logic [TIME_BITS-1:0] fire_q;

	logic                 first;
	logic                 due;
	logic [TIME_BITS-1:0] dur;
	logic [TIME_BITS-1:0] since;
	logic [TIME_BITS-1:0] delay_ext;
	logic [TIME_BITS-1:0] rate_ext;
	logic [TIME_BITS-1:0] wait_us;

	// Differences wrap modulo the time width, as the time base does.
	always_comb begin
		delay_ext = TIME_BITS'(delay);
		rate_ext  = TIME_BITS'(rate);
		dur       = now - start_q;
		since     = now - fire_q;
		wait_us   = (dur < delay_ext) ? delay_ext : rate_ext;
		first     = held && !seen_q;
		due       = held && seen_q && (since >= wait_us);
		press     = poll && (first || due);
		seen_nx   = poll ? held : seen_q;
		start_nx  = (poll && first) ? now : start_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= 1'b0;
			start_q <= '0;
			fire_q  <= '0;
		end else if (poll) begin
			seen_q <= held;
			if (first) begin
				start_q <= now;
				fire_q  <= now;
			end else if (due) begin
				fire_q <= now;
			end
		end
	end

endmodule

`default_nettype wire

/* design/mkar_core.sv */
// Key snapshot edge logic, direction mapping and result assembly.
// Depends on mkar_pkg and two mkar_repeat lanes.
`timescale 1ns / 1ps
`default_nettype none

module mkar_core import mkar_pkg::*; #(
	parameter int TIME_BITS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t result
);

	logic       menu_q;
	logic       alt_q;
	logic       enter_q;
	logic       esc_q;
	logic       pending_q;
	logic [1:0] held_q;

	logic       is_poll;
	logic       snap_acc;
	logic       poll_acc;
	logic       active;
	logic       nav;
	logic       enter_edge;
	logic       esc_edge;
	logic [1:0] held_map;

	logic [TIME_BITS-1:0] now;
	logic [1:0]           press;
	logic [1:0]           seen;
	logic [TIME_BITS-1:0] start [2];

	always_comb begin
		is_poll    = (item.cmd == CMD_POLL);
		snap_acc   = accept && (item.cmd == CMD_SNAPSHOT);
		poll_acc   = accept && is_poll;
		active     = item.menu_open || item.alt_overlay_keys;
		nav        = item.menu_open && !item.adjusting;
		enter_edge = item.keys[KB_ENTER] && !enter_q;
		esc_edge   = item.keys[KB_ESC] && !esc_q;
		// In navigation mode left/right walk the list; otherwise right raises a value.
		held_map[DIR_UP]   = item.keys[KB_UP] ||
			(nav ? item.keys[KB_LEFT] : item.keys[KB_RIGHT]);
		held_map[DIR_DOWN] = item.keys[KB_DOWN] ||
			(nav ? item.keys[KB_RIGHT] : item.keys[KB_LEFT]);
		now = item.now_us[TIME_BITS-1:0];
	end

	for (genvar d = 0; d < 2; d++) begin : g_lane
		mkar_repeat #(
			.TIME_BITS(TIME_BITS)
		) u_repeat (
			.clk     (clk),
			.arst_n  (arst_n),
			.poll    (poll_acc),
			.held    (held_q[d]),
			.now     (now),
			.delay   (cfg.repeat_delay_us),
			.rate    (cfg.repeat_rate_us),
			.press   (press[d]),
			.seen_nx (seen[d]),
			.start_nx(start[d])
		);
	end

	always_comb begin
		result = '0;
		if (is_poll) begin
			result.select_press = pending_q;
			result.up_press     = press[DIR_UP];
			result.down_press   = press[DIR_DOWN];
		end else begin
			result.menu_request = item.keys[KB_MENU] && !menu_q;
			result.alt_request  = item.keys[KB_ALT] && !alt_q && !item.menu_open &&
				cfg.alt_hotkey_enabled;
			if (active) begin
				result.keyboard_owned = 1'b1;
				if (esc_edge) begin
					if (item.alt_overlay_keys && !item.menu_open) begin
						result.alt_overlay_release = 1'b1;
					end else begin
						result.back_press = 1'b1;
					end
				end
			end
		end
		result.up_is_held      = seen[DIR_UP];
		result.down_is_held    = seen[DIR_DOWN];
		result.up_hold_began   = 64'(start[DIR_UP]);
		result.down_hold_began = 64'(start[DIR_DOWN]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			menu_q    <= 1'b0;
			alt_q     <= 1'b0;
			enter_q   <= 1'b0;
			esc_q     <= 1'b0;
			pending_q <= 1'b0;
			held_q    <= 2'b00;
		end else if (snap_acc) begin
			menu_q  <= item.keys[KB_MENU];
			alt_q   <= item.keys[KB_ALT];
			enter_q <= item.keys[KB_ENTER];
			esc_q   <= item.keys[KB_ESC];
			// With no overlay the edge trackers still follow the keys, so opening
			// the overlay with enter or escape held gives no edge.
			held_q  <= active ? held_map : 2'b00;
			if (active && enter_edge) begin
				pending_q <= 1'b1;
			end
		end else if (poll_acc) begin
			pending_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

/* design/mkar_obuf.sv */
// Two-entry output buffer: result register plus a skid entry.
// Depends on mkar_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none

module mkar_obuf import mkar_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  out_item_t in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic      main_valid_q;
	logic      skid_valid_q;
	out_item_t main_q;
	out_item_t skid_q;
	logic      in_fire;
	logic      out_fire;

	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;
	assign in_fire   = in_valid && !skid_valid_q;
	assign out_fire  = main_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_fire) begin
			if (main_valid_q && !out_fire) begin
				skid_valid_q <= 1'b1;
			end
			main_valid_q <= 1'b1;
		end else if (out_fire) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				main_q <= skid_q;
			end
		end else if (in_fire) begin
			if (main_valid_q && !out_fire) begin
				skid_q <= in_data;
			end else begin
				main_q <= in_data;
			end
		end
	end

endmodule

`default_nettype wire

/* design/menu_key_edge_and_autorepeat.sv */
// Top level: keyboard snapshots and time polls in, menu navigation pulses out.
// Depends on mkar_pkg, mkar_cfg, mkar_core, mkar_obuf and the assertion header.
//
//   Channel   Handshake                      Payload
//   item      item_valid / item_ready        in_item_t item
//   result    result_valid / result_ready    out_item_t result
//   config    cfg_we (no wait)               cfg_index, cfg_data
//
// One transaction is accepted per cycle while item_ready is high; its
// result is registered. The work is a single pass of edge logic and two
// wrapping subtract-compare timers. A two-entry output buffer lets one more
// transaction in while a result is stalled; item_ready drops only when both
// entries are full. Reset clears all state and loads the default delay/rate.
`timescale 1ns / 1ps
`default_nettype none
`include "menu_key_edge_and_autorepeat_defines.svh"

module menu_key_edge_and_autorepeat import mkar_pkg::*; #(
	parameter int TIME_BITS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_ready,
	input  in_item_t                 item,
	output logic                     result_valid,
	input  logic                     result_ready,
	output out_item_t                result,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	cfg_t      cfg;
	out_item_t core_result;
	logic      accept;

	assign accept = item_valid && item_ready;

	mkar_cfg u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.index (cfg_index),
		.data  (cfg_data),
		.cfg   (cfg)
	);

	mkar_core #(
		.TIME_BITS(TIME_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.item  (item),
		.cfg   (cfg),
		.result(core_result)
	);

	mkar_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.in_ready (item_ready),
		.in_data  (core_result),
		.out_valid(result_valid),
		.out_ready(result_ready),
		.out_data (result)
	);

	// The buffer only refuses input when a result is waiting at the output.
	`MKAR_ASSERT_IMPL(a_ready_low_needs_result, clk, arst_n, !item_ready, result_valid, "item_ready low with empty output")

	// An accepted transaction into an empty buffer is visible on the next cycle.
	`MKAR_ASSERT_NEXT(a_result_follows, clk, arst_n, accept && !result_valid, result_valid, "accepted transaction produced no result")

	// Poll pulses and snapshot pulses never share one result.
	`MKAR_ASSERT_IMPL(a_kinds_exclusive, clk, arst_n, result_valid && (result.select_press || result.up_press || result.down_press), !(result.menu_request || result.alt_request || result.alt_overlay_release || result.keyboard_owned || result.back_press), "poll and snapshot fields mixed")

	// A direction press only happens while that direction is held.
	`MKAR_ASSERT_IMPL(a_press_needs_hold, clk, arst_n, result_valid && (result.up_press || result.down_press), (!result.up_press || result.up_is_held) && (!result.down_press || result.down_is_held), "press without hold")

endmodule

`default_nettype wire
